[rtl/cts_pkg.sv]
package cts_pkg;

   // Seed pair kept for one row of the crypt table.
   typedef struct packed {
      logic [31:0] one;
      logic [31:0] two;
   } seed_pair_type;

   localparam logic [31:0] SEED_ONE_INIT = 32'h7FED7FED;
   localparam logic [31:0] SEED_TWO_INIT = 32'hEEEEEEEE;
   localparam seed_pair_type SEED_PAIR_INIT = '{one: SEED_ONE_INIT, two: SEED_TWO_INIT};

   // Mixing step constants.
   localparam int unsigned MIX_SHIFT = 5;
   localparam logic [31:0] MIX_INC = 32'd3;

   // Length bookkeeping: bytes are packed while fewer than eight have been seen,
   // and the count stops one past that.
   localparam logic [3:0] SHORT_MAX = 4'd8;
   localparam logic [3:0] COUNT_SAT = 4'd9;

   // Crypt table generator.
   localparam logic [31:0] LCG_SEED = 32'h00100001;
   localparam logic [31:0] LCG_MULT = 32'd125;
   localparam logic [31:0] LCG_INC = 32'd3;
   localparam logic [31:0] LCG_MOD = 32'h002AAAAB;
   localparam logic [31:0] HALF_MASK = 32'h0000FFFF;
   localparam int unsigned ROM_COLS = 256;
   localparam int unsigned ROM_ROWS = 5;
   localparam int unsigned CRYPT_TAB_MAX = ROM_COLS * ROM_ROWS;
   localparam int unsigned TABLE_ENTRIES_DEF = 512;

   typedef logic [CRYPT_TAB_MAX-1:0][31:0] crypt_tab_type;

   // Builds the whole table at elaboration. Two generator steps make one word,
   // the first giving the upper half and the second the lower half.
   function automatic crypt_tab_type crypt_table_gen();
      crypt_tab_type tab;
      logic [31:0] seed;
      logic [31:0] hi;
      logic [31:0] lo;
      int unsigned addr;
      seed = LCG_SEED;
      for (int unsigned col = 0; col < ROM_COLS; col++) begin
         for (int unsigned row = 0; row < ROM_ROWS; row++) begin
            addr = col + row * ROM_COLS;
            seed = (seed * LCG_MULT + LCG_INC) % LCG_MOD;
            hi = (seed & HALF_MASK) << 16;
            seed = (seed * LCG_MULT + LCG_INC) % LCG_MOD;
            lo = seed & HALF_MASK;
            tab[addr] = hi | lo;
         end
      end
      return tab;
   endfunction

endpackage

[rtl/cts_rom.sv]
module cts_rom #(
   parameter int unsigned TABLE_ENTRIES = cts_pkg::TABLE_ENTRIES_DEF
) (
   input  logic        clock,
   input  logic        rd_en,
   input  logic [7:0]  rd_byte,
   output logic [31:0] row0_data,
   output logic [31:0] row1_data
);
   import cts_pkg::*;

   localparam int unsigned ADDR_W = $clog2(TABLE_ENTRIES);
   localparam crypt_tab_type FULL_TAB = crypt_table_gen();

   logic [31:0]       rom_tab [TABLE_ENTRIES];
   logic [ADDR_W-1:0] addr0;
   logic [ADDR_W-1:0] addr1;
   logic [31:0]       row0_data_ff;
   logic [31:0]       row1_data_ff;

   always_comb begin
      for (int unsigned i = 0; i < TABLE_ENTRIES; i++) begin
         rom_tab[i] = FULL_TAB[i];
      end
   end

   // Row 0 sits at the byte value, row 1 one row of ROM_COLS entries above it.
   assign addr0 = ADDR_W'(rd_byte);
   assign addr1 = ADDR_W'({1'b1, rd_byte});

   always_ff @(posedge clock) begin
      if (rd_en) begin
         row0_data_ff <= rom_tab[addr0];
         row1_data_ff <= rom_tab[addr1];
      end
   end

   assign row0_data = row0_data_ff;
   assign row1_data = row1_data_ff;

endmodule

[rtl/cts_mix.sv]
module cts_mix (
   input  cts_pkg::seed_pair_type seed_cur,
   input  logic [31:0]            rom_word,
   input  logic [7:0]             data_byte,
   output cts_pkg::seed_pair_type seed_nxt
);
   import cts_pkg::*;

   logic [31:0] mixed;

   assign mixed = rom_word ^ (seed_cur.one + seed_cur.two);

   always_comb begin
      seed_nxt.one = mixed;
      seed_nxt.two = 32'(data_byte) + mixed + seed_cur.two + (seed_cur.two << MIX_SHIFT)
                     + MIX_INC;
   end

endmodule

[rtl/crypt_table_string_hash.sv]
// A result appears on rsp_valid once the request marked last has passed the request stage and
// the output register. One request per cycle when not stalled; the two-port ROM read and the
// seed update are each registered, and the seed registers close the only loop, so requests go
// back to back. The input stalls only while a finished result waits on a stalled output and the
// next final request needs the output register. Reset is synchronous and active high; it clears
// the seeds, count, packed bytes, mode and valids. The ROM is constant, so there is no fill pass.
module crypt_table_string_hash #(
   parameter int unsigned TABLE_ENTRIES = cts_pkg::TABLE_ENTRIES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel: at most one string byte per request.
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_has_byte,
   input  logic        req_last_byte,
   // Result channel.
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_sign_value,
   // Mode register write port.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_wide_mode
);
   import cts_pkg::*;

   // The request stage holds the byte and its flags while the ROM words are read.
   logic          s1_valid_ff;
   logic          s1_valid_in;
   logic [7:0]    s1_byte_ff;
   logic          s1_has_ff;
   logic          s1_last_ff;
   logic          s1_adv;
   logic          req_accept;

   logic [31:0]   rom_row0;
   logic [31:0]   rom_row1;

   // Per-string state.
   seed_pair_type row0_ff;
   seed_pair_type row0_in;
   seed_pair_type row1_ff;
   seed_pair_type row1_in;
   seed_pair_type row0_mix;
   seed_pair_type row1_mix;
   logic [3:0]    count_ff;
   logic [3:0]    count_in;
   logic [63:0]   short_ff;
   logic [63:0]   short_in;

   // State after the current byte, before any end-of-string clear.
   seed_pair_type upd_row0;
   seed_pair_type upd_row1;
   logic [3:0]    upd_count;
   logic [63:0]   upd_short;

   logic          wide_mode_ff;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   logic [63:0]   rsp_value_ff;
   logic [63:0]   rsp_value_in;
   logic          rsp_load;

   // The stage moves on unless it holds a final request whose result has nowhere to go.
   assign s1_adv     = !s1_valid_ff || !s1_last_ff || !rsp_valid_ff || !rsp_stall;
   assign req_stall  = !s1_adv;
   assign req_accept = req_valid && !req_stall;
   assign s1_valid_in = s1_adv ? req_accept : s1_valid_ff;
   assign rsp_load   = s1_valid_ff && s1_last_ff && s1_adv;

   // The mode register may be written at any time.
   assign csr_ready = 1'b1;

   cts_rom #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_rom (
      .clock     (clock),
      .rd_en     (s1_adv),
      .rd_byte   (req_data_byte),
      .row0_data (rom_row0),
      .row1_data (rom_row1)
   );

   cts_mix u_mix_row0 (
      .seed_cur  (row0_ff),
      .rom_word  (rom_row0),
      .data_byte (s1_byte_ff),
      .seed_nxt  (row0_mix)
   );

   cts_mix u_mix_row1 (
      .seed_cur  (row1_ff),
      .rom_word  (rom_row1),
      .data_byte (s1_byte_ff),
      .seed_nxt  (row1_mix)
   );

   // Fold in the byte. Bytes are packed into their lane while fewer than eight
   // have been seen; the count saturates so a long string is recognized.
   always_comb begin
      upd_row0  = row0_ff;
      upd_row1  = row1_ff;
      upd_count = count_ff;
      upd_short = short_ff;
      if (s1_has_ff) begin
         upd_row0 = row0_mix;
         upd_row1 = row1_mix;
         for (int i = 0; i < 8; i++) begin
            if (count_ff == 4'(i)) begin
               upd_short[8*i +: 8] = s1_byte_ff;
            end
         end
         if (count_ff < COUNT_SAT) begin
            upd_count = count_ff + 4'd1;
         end
      end
   end

   // Result selection, using the state that includes the final byte.
   always_comb begin
      if (!wide_mode_ff) begin
         rsp_value_in = {32'd0, upd_row0.one};
      end else if (upd_count <= SHORT_MAX) begin
         rsp_value_in = upd_short;
      end else begin
         rsp_value_in = {upd_row1.one, upd_row0.one};
      end
   end

   // The string state returns to its start values once the final request is done.
   always_comb begin
      row0_in  = row0_ff;
      row1_in  = row1_ff;
      count_in = count_ff;
      short_in = short_ff;
      if (s1_valid_ff && s1_adv) begin
         if (s1_last_ff) begin
            row0_in  = SEED_PAIR_INIT;
            row1_in  = SEED_PAIR_INIT;
            count_in = 4'd0;
            short_in = 64'd0;
         end else begin
            row0_in  = upd_row0;
            row1_in  = upd_row1;
            count_in = upd_count;
            short_in = upd_short;
         end
      end
   end

   assign rsp_valid_in = (rsp_valid_ff && rsp_stall) || rsp_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         row0_ff      <= SEED_PAIR_INIT;
         row1_ff      <= SEED_PAIR_INIT;
         count_ff     <= 4'd0;
         short_ff     <= 64'd0;
         wide_mode_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         row0_ff      <= row0_in;
         row1_ff      <= row1_in;
         count_ff     <= count_in;
         short_ff     <= short_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            wide_mode_ff <= csr_wide_mode;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s1_byte_ff <= req_data_byte;
         s1_has_ff  <= req_has_byte;
         s1_last_ff <= req_last_byte;
      end
      if (rsp_load) begin
         rsp_value_ff <= rsp_value_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sign_value = rsp_value_ff;

endmodule
